### rtl/deq_pkg.sv
// Package: sizes, command and status codes, and index helpers for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    // Capacity and derived widths
    localparam int DEPTH    = 16;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int WORD_W   = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 5;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CLEAR      = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Slot index plus offset, modulo DEPTH; offset is at most DEPTH
    function automatic t_addr idx_add(input t_addr idx, input t_cnt off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(idx) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return ADDR_W'(sum);
    endfunction

    // Slot index minus one, modulo DEPTH
    function automatic t_addr idx_dec(input t_addr idx);
        t_addr res;
        if (idx == '0) begin
            res = ADDR_W'(DEPTH - 1);
        end else begin
            res = idx - ADDR_W'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/deq_if.sv
// Interfaces: command channel and result channel of the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

interface deq_cmd_if;
    import deq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface deq_res_if;
    import deq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] removed_value;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
    logic [ENTRY_W-1:0]       entry_count;
    logic                     is_empty;

    modport source (output valid, output status, output removed_value, output front_value,
                    output back_value, output entry_count, output is_empty, input ready);
    modport sink   (input valid, input status, input removed_value, input front_value,
                    input back_value, input entry_count, input is_empty, output ready);
endinterface

`default_nettype wire

### rtl/deq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/double_ended_queue_top.sv
// Top level: bounded double-ended queue of signed words in a circular RAM.
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of DEPTH signed 32-bit words. Each command transfer
// (push front, push back, pop front, pop back, clear; other codes do nothing)
// yields exactly one result transfer with status, removed word, front and back
// words, entry count and empty flag. Words live in a simple dual-port RAM; the
// front and back words are also held in registers so every result can report
// them. A command goes from acceptance through S_DONE back to S_IDLE; a pop
// that leaves the queue non-empty also goes through S_READ, since the new end
// word comes from the registered RAM read port. A result waiting in the output
// register delays the next command only when the following result is ready
// before the waiting one is taken. No clearing pass is needed after reset.
module double_ended_queue_top
    import deq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    deq_cmd_if.sink    i_cmd,
    deq_res_if.source  o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DONE
    } t_state;

    t_state                   r_state;
    t_addr                    r_front_idx;
    t_cnt                     r_count;
    logic signed [WORD_W-1:0] r_front_w;
    logic signed [WORD_W-1:0] r_back_w;
    t_status                  r_status;
    logic signed [WORD_W-1:0] r_removed;
    logic                     r_rd_front;

    logic                     r_o_valid;
    logic [STATUS_W-1:0]      r_o_status;
    logic signed [WORD_W-1:0] r_o_removed;
    logic signed [WORD_W-1:0] r_o_front;
    logic signed [WORD_W-1:0] r_o_back;
    logic [ENTRY_W-1:0]       r_o_count;
    logic                     r_o_empty;

    t_addr                    n_front_idx;
    t_cnt                     n_count;
    logic signed [WORD_W-1:0] n_front_w;
    logic signed [WORD_W-1:0] n_back_w;
    t_status                  n_status;
    logic signed [WORD_W-1:0] n_removed;
    logic                     n_rd_front;
    logic                     n_need_rd;

    logic                     cmd_fire;
    logic                     out_free;
    logic                     q_full;
    logic                     q_empty;
    logic                     wr_en;
    t_addr                    wr_addr;
    t_addr                    rd_addr;
    logic [WORD_W-1:0]        rd_data;

    assign cmd_fire    = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign out_free    = !r_o_valid || o_res.ready;
    assign q_full      = (r_count == CNT_W'(DEPTH));
    assign q_empty     = (r_count == '0);

    // Command decode: pointer and count update, RAM access, end-word cache
    always_comb begin
        n_front_idx = r_front_idx;
        n_count     = r_count;
        n_front_w   = r_front_w;
        n_back_w    = r_back_w;
        n_status    = ST_OK;
        n_removed   = '0;
        n_rd_front  = 1'b0;
        n_need_rd   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = idx_add(r_front_idx, r_count);
        rd_addr     = idx_add(r_front_idx, CNT_W'(1));
        case (i_cmd.command)
            CMD_PUSH_FRONT: begin
                if (q_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_front_idx = idx_dec(r_front_idx);
                    n_count     = r_count + CNT_W'(1);
                    wr_en       = 1'b1;
                    wr_addr     = idx_dec(r_front_idx);
                    n_front_w   = i_cmd.value;
                    if (q_empty) begin
                        n_back_w = i_cmd.value;
                    end
                end
            end
            CMD_PUSH_BACK: begin
                if (q_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count  = r_count + CNT_W'(1);
                    wr_en    = 1'b1;
                    n_back_w = i_cmd.value;
                    if (q_empty) begin
                        n_front_w = i_cmd.value;
                    end
                end
            end
            CMD_POP_FRONT: begin
                if (q_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_removed   = r_front_w;
                    n_front_idx = idx_add(r_front_idx, CNT_W'(1));
                    n_count     = r_count - CNT_W'(1);
                    n_rd_front  = 1'b1;
                    n_need_rd   = (r_count != CNT_W'(1));
                end
            end
            CMD_POP_BACK: begin
                if (q_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_removed = r_back_w;
                    n_count   = r_count - CNT_W'(1);
                    rd_addr   = idx_add(r_front_idx, r_count - CNT_W'(2));
                    n_need_rd = (r_count != CNT_W'(1));
                end
            end
            CMD_CLEAR: begin
                n_front_idx = '0;
                n_count     = '0;
            end
            default: begin
            end
        endcase
    end

    deq_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (WORD_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cmd_fire && wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_cmd.value),
        .i_rd_en   (cmd_fire && n_need_rd),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Sequencer, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front_idx <= '0;
            r_count     <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            // output valid: load a new result or drop after its transfer
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (cmd_fire) begin
                        r_front_idx <= n_front_idx;
                        r_count     <= n_count;
                        r_front_w   <= n_front_w;
                        r_back_w    <= n_back_w;
                        r_status    <= n_status;
                        r_removed   <= n_removed;
                        r_rd_front  <= n_rd_front;
                        r_state     <= n_need_rd ? S_READ : S_DONE;
                    end
                end
                S_READ: begin
                    // new end word arrives from the RAM
                    if (r_rd_front) begin
                        r_front_w <= rd_data;
                    end else begin
                        r_back_w <= rd_data;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_status  <= r_status;
                        r_o_removed <= r_removed;
                        r_o_front   <= q_empty ? '0 : r_front_w;
                        r_o_back    <= q_empty ? '0 : r_back_w;
                        r_o_count   <= ENTRY_W'(r_count);
                        r_o_empty   <= q_empty;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid         = r_o_valid;
    assign o_res.status        = r_o_status;
    assign o_res.removed_value = r_o_removed;
    assign o_res.front_value   = r_o_front;
    assign o_res.back_value    = r_o_back;
    assign o_res.entry_count   = r_o_count;
    assign o_res.is_empty      = r_o_empty;

endmodule

`default_nettype wire

### rtl/deq_checker.sv
// Checker: port-level assertions for the double-ended queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module deq_checker
    import deq_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_res_valid,
    input wire logic                     i_res_ready,
    input wire logic [STATUS_W-1:0]      i_status,
    input wire logic signed [WORD_W-1:0] i_removed,
    input wire logic signed [WORD_W-1:0] i_front,
    input wire logic signed [WORD_W-1:0] i_back,
    input wire logic [ENTRY_W-1:0]       i_count,
    input wire logic                     i_empty
);

    // Empty flag agrees with the count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_empty == (i_count == '0)))
        else $error("is_empty disagrees with entry_count");

    // An empty queue reports zero end words
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_empty) |-> (i_front == '0 && i_back == '0))
        else $error("empty queue reports nonzero end words");

    // A failed command removes nothing
    a_err_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_status != ST_OK) |-> (i_removed == '0))
        else $error("error result carries a removed word");

    // A full error only occurs at capacity, an empty error only when empty
    a_err_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> ((i_status != ST_EMPTY || i_empty) &&
                         (i_status != ST_FULL || i_count == ENTRY_W'(DEPTH))))
        else $error("error status inconsistent with entry count");

    // A stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_status) &&
            $stable(i_removed) && $stable(i_front) && $stable(i_back) && $stable(i_count)))
        else $error("stalled result changed");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_removed   (o_res.removed_value),
    .i_front     (o_res.front_value),
    .i_back      (o_res.back_value),
    .i_count     (o_res.entry_count),
    .i_empty     (o_res.is_empty)
);

`default_nettype wire

### sim/deq_result_checker.sv
// Checker: predicts each double-ended queue result and compares it with the result channel.
`timescale 1ns / 1ps

module deq_result_checker
    import deq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    deq_cmd_if        i_cmd,
    deq_res_if        i_res,
    output int        o_fail_count,
    output int        o_pending_count,
    output int        o_cmd_count,
    output int        o_result_count,
    output int        o_full_rejects,
    output int        o_empty_rejects,
    output int        o_peak_fill
);

    // One result as the block should report it
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] removed_value;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] back_value;
        logic [ENTRY_W-1:0]       entry_count;
        logic                     is_empty;
    } t_deq_outcome;

    // Shadow copy of the queue contents
    logic signed [WORD_W-1:0] shadow_words [DEPTH];
    int                       head_slot;
    int                       live_count;

    t_deq_outcome             awaited_outcomes [$];
    t_deq_outcome             oldest;

    int                       fail_count;
    int                       cmd_count;
    int                       result_count;
    int                       full_rejects;
    int                       empty_rejects;
    int                       peak_fill;

    function automatic int slot_of(input int offset);
        return (head_slot + offset) % DEPTH;
    endfunction

    // Apply one command to the shadow queue and build the result it causes
    function automatic t_deq_outcome predict_outcome(input logic [CMD_W-1:0] code,
                                                     input logic signed [WORD_W-1:0] word);
        t_deq_outcome outcome;
        outcome        = '0;
        outcome.status = ST_OK;
        case (code)
            CMD_PUSH_FRONT: begin
                if (live_count >= DEPTH) begin
                    outcome.status = ST_FULL;
                end else begin
                    head_slot               = (head_slot + DEPTH - 1) % DEPTH;
                    shadow_words[head_slot] = word;
                    live_count++;
                end
            end
            CMD_PUSH_BACK: begin
                if (live_count >= DEPTH) begin
                    outcome.status = ST_FULL;
                end else begin
                    shadow_words[slot_of(live_count)] = word;
                    live_count++;
                end
            end
            CMD_POP_FRONT: begin
                if (live_count == 0) begin
                    outcome.status = ST_EMPTY;
                end else begin
                    outcome.removed_value = shadow_words[head_slot];
                    head_slot             = slot_of(1);
                    live_count--;
                end
            end
            CMD_POP_BACK: begin
                if (live_count == 0) begin
                    outcome.status = ST_EMPTY;
                end else begin
                    outcome.removed_value = shadow_words[slot_of(live_count - 1)];
                    live_count--;
                end
            end
            CMD_CLEAR: begin
                head_slot  = 0;
                live_count = 0;
            end
            default: begin
                // unused codes leave the queue as it is
            end
        endcase
        // only live slots are read, so unwritten entries never matter
        if (live_count != 0) begin
            outcome.front_value = shadow_words[head_slot];
            outcome.back_value  = shadow_words[slot_of(live_count - 1)];
        end
        outcome.entry_count = ENTRY_W'(live_count);
        outcome.is_empty    = (live_count == 0);
        return outcome;
    endfunction

    // Result first, then command: a result never belongs to a command of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_slot     = 0;
            live_count    = 0;
            fail_count    = 0;
            cmd_count     = 0;
            result_count  = 0;
            full_rejects  = 0;
            empty_rejects = 0;
            peak_fill     = 0;
            awaited_outcomes.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (awaited_outcomes.size() == 0) begin
                    $error("result transfer with no pending expectation");
                    fail_count++;
                end else begin
                    oldest = awaited_outcomes.pop_front();
                    result_count++;
                    if (i_res.status !== oldest.status) begin
                        $error("status: expected %0d, actual %0d", oldest.status, i_res.status);
                        fail_count++;
                    end
                    if (i_res.removed_value !== oldest.removed_value) begin
                        $error("removed_value: expected %0d, actual %0d",
                               oldest.removed_value, i_res.removed_value);
                        fail_count++;
                    end
                    if (i_res.front_value !== oldest.front_value) begin
                        $error("front_value: expected %0d, actual %0d",
                               oldest.front_value, i_res.front_value);
                        fail_count++;
                    end
                    if (i_res.back_value !== oldest.back_value) begin
                        $error("back_value: expected %0d, actual %0d",
                               oldest.back_value, i_res.back_value);
                        fail_count++;
                    end
                    if (i_res.entry_count !== oldest.entry_count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               oldest.entry_count, i_res.entry_count);
                        fail_count++;
                    end
                    if (i_res.is_empty !== oldest.is_empty) begin
                        $error("is_empty: expected %0d, actual %0d",
                               oldest.is_empty, i_res.is_empty);
                        fail_count++;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                awaited_outcomes.push_back(predict_outcome(i_cmd.command, i_cmd.value));
                cmd_count++;
                if (awaited_outcomes[$].status == ST_FULL) begin
                    full_rejects++;
                end
                if (awaited_outcomes[$].status == ST_EMPTY) begin
                    empty_rejects++;
                end
                if (live_count > peak_fill) begin
                    peak_fill = live_count;
                end
            end
        end
        o_fail_count    <= fail_count;
        o_pending_count <= awaited_outcomes.size();
        o_cmd_count     <= cmd_count;
        o_result_count  <= result_count;
        o_full_rejects  <= full_rejects;
        o_empty_rejects <= empty_rejects;
        o_peak_fill     <= peak_fill;
    end

endmodule

### sim/double_ended_queue_top_tb.sv
// Testbench top: clock, reset, command stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module double_ended_queue_top_tb;
    import deq_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 4;
    localparam int RANDOM_ITEMS  = 620;
    localparam int HOLD_AT       = 200;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TIMEOUT_NS    = 5_000_000;

    // Codes with no operation behind them
    localparam logic [CMD_W-1:0] CMD_NOP_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_NOP_HI = 3'd7;

    // Command mix of one burst
    localparam int BIAS_FILL  = 0;
    localparam int BIAS_DRAIN = 1;
    localparam int BIAS_MIXED = 2;

    // Receiver ready patterns
    localparam int READY_ALWAYS = 0;
    localparam int READY_HALF   = 1;
    localparam int READY_SPARSE = 2;

    logic i_clk;
    logic i_rst_n;
    bit   hold_trigger;
    bit   hold_done;

    int   fail_count;
    int   pending_count;
    int   cmd_count;
    int   result_count;
    int   full_rejects;
    int   empty_rejects;
    int   peak_fill;

    deq_cmd_if cmd_ch ();
    deq_res_if res_ch ();

    double_ended_queue_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    deq_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd_ch),
        .i_res           (res_ch),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count),
        .o_cmd_count     (cmd_count),
        .o_result_count  (result_count),
        .o_full_rejects  (full_rejects),
        .o_empty_rejects (empty_rejects),
        .o_peak_fill     (peak_fill)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("double_ended_queue_top verification failed");
        $finish;
    end

    // Words: extremes, zero and all-ones show up often
    function automatic logic signed [WORD_W-1:0] pick_word();
        int roll;
        logic signed [WORD_W-1:0] word;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            word = 32'sh7FFF_FFFF;
        end else if (roll < 20) begin
            word = 32'sh8000_0000;
        end else if (roll < 25) begin
            word = '0;
        end else if (roll < 30) begin
            word = '1;
        end else begin
            word = $urandom;
        end
        return word;
    endfunction

    // Pushes or pops dominate according to the burst mix
    function automatic logic [CMD_W-1:0] pick_command(input int bias);
        int roll;
        int push_pct;
        logic [CMD_W-1:0] code;
        roll     = $urandom_range(0, 99);
        push_pct = (bias == BIAS_FILL) ? 80 : (bias == BIAS_DRAIN) ? 20 : 50;
        if (roll < 2) begin
            code = CMD_CLEAR;
        end else if (roll < 5) begin
            code = CMD_W'($urandom_range(CMD_NOP_LO, CMD_NOP_HI));
        end else if ($urandom_range(0, 99) < push_pct) begin
            code = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        end else begin
            code = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        end
        return code;
    endfunction

    // Offer one command and hold it until the transfer
    task automatic send_command(input logic [CMD_W-1:0] code,
                                input logic signed [WORD_W-1:0] word);
        @(negedge i_clk);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= code;
        cmd_ch.value   <= word;
        do begin
            @(posedge i_clk);
        end while (!cmd_ch.ready);
    endtask

    // Idle the command side, with junk on the payload
    task automatic pause_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            cmd_ch.valid   <= 1'b0;
            cmd_ch.command <= CMD_W'($urandom);
            cmd_ch.value   <= $urandom;
        end
    endtask

    // Result side: stretches of ready patterns, one long hold-off on request
    initial begin
        int stretch;
        int mode;
        res_ch.ready = 1'b0;
        forever begin
            stretch = $urandom_range(8, 40);
            mode    = $urandom_range(READY_ALWAYS, READY_SPARSE);
            repeat (stretch) begin
                @(negedge i_clk);
                if (hold_trigger && !hold_done) begin
                    res_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                    hold_done = 1'b1;
                end else begin
                    case (mode)
                        READY_ALWAYS: res_ch.ready <= 1'b1;
                        READY_HALF:   res_ch.ready <= 1'($urandom_range(0, 1));
                        default:      res_ch.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    // Reset, directed commands, random bursts, drain and verdict
    initial begin
        int               bias;
        int               burst;
        int               driven;
        int               waited;
        logic [CMD_W-1:0] code;

        i_rst_n        = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.command = '0;
        cmd_ch.value   = '0;
        hold_trigger   = 1'b0;
        hold_done      = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty queue: pops fail, clear and unused codes report nothing stored
        send_command(CMD_POP_FRONT, pick_word());
        send_command(CMD_POP_BACK, pick_word());
        send_command(CMD_CLEAR, pick_word());
        send_command(CMD_NOP_HI, pick_word());
        // Extremes in, then remove both again, emptying the queue
        send_command(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_command(CMD_PUSH_BACK, 32'sh8000_0000);
        send_command(CMD_NOP_LO, pick_word());
        send_command(CMD_POP_FRONT, pick_word());
        send_command(CMD_POP_BACK, pick_word());
        // Fill from both ends, wrapping below slot zero, then push on full, pop back and clear
        for (int k = 0; k < DEPTH; k++) begin
            send_command((k % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_word());
        end
        send_command(CMD_PUSH_FRONT, pick_word());
        send_command(CMD_PUSH_BACK, pick_word());
        send_command(CMD_POP_BACK, pick_word());
        send_command(CMD_CLEAR, pick_word());

        driven = 0;
        while (driven < RANDOM_ITEMS) begin
            bias  = $urandom_range(BIAS_FILL, BIAS_MIXED);
            burst = $urandom_range(1, 32);
            repeat (burst) begin
                code = pick_command(bias);
                send_command(code, pick_word());
                if (code <= CMD_CLEAR) begin
                    driven++;
                end
                if (driven == HOLD_AT) begin
                    hold_trigger = 1'b1;
                end
            end
            if ($urandom_range(0, 3) != 0) begin
                pause_sender($urandom_range(1, 8));
            end
        end
        pause_sender(1);

        waited = 0;
        while (pending_count != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (pending_count != 0) begin
            $error("%0d expected results never arrived", pending_count);
        end
        $display("Run covered %0d commands and %0d checked results; peak fill %0d of %0d.",
                 cmd_count, result_count, peak_fill, DEPTH);
        $display("Rejected pushes on full: %0d, rejected pops on empty: %0d.",
                 full_rejects, empty_rejects);
        if (fail_count == 0 && pending_count == 0) begin
            $display("double_ended_queue_top verification clean");
        end else begin
            $display("double_ended_queue_top verification failed");
        end
        $finish;
    end

endmodule
